FILE: rtl/ocsu_pkg.sv
// shared types, constants and helper functions for the occupancy cell state update block
package ocsu_pkg;

    // grid geometry and storage sizes
    localparam int GRID_ROWS = 128;
    localparam int GRID_COLS = 128;
    localparam int VIEW_BITS = 16;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = 7;
    localparam int COL_W     = 7;
    localparam int STATE_W   = 3;
    localparam int FRONT_W   = 15;
    localparam int NB_COUNT  = 8;
    localparam int NB_CNT_W  = $clog2(NB_COUNT + 1);
    localparam int NB_IDX_W  = $clog2(NB_COUNT);

    // cell state codes
    localparam logic [STATE_W-1:0] ST_UNKNOWN  = 3'd0;
    localparam logic [STATE_W-1:0] ST_FREE     = 3'd1;
    localparam logic [STATE_W-1:0] ST_OCCUPIED = 3'd2;
    localparam logic [STATE_W-1:0] ST_VISITED  = 3'd3;
    localparam logic [STATE_W-1:0] ST_FRONTIER = 3'd4;

    localparam logic [VIEW_BITS-1:0] VIEW_MAX = {VIEW_BITS{1'b1}};

    // request item
    typedef struct packed {
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [STATE_W-1:0] wanted_state;
        logic               force_req;
    } req_t;

    // result item
    typedef struct packed {
        logic                 applied;
        logic [STATE_W-1:0]   prior_state;
        logic [STATE_W-1:0]   stored_state;
        logic [15:0]          view_count;
        logic [FRONT_W-1:0]   frontier_total;
        logic [ROW_W-1:0]     box_min_row;
        logic [COL_W-1:0]     box_min_col;
        logic [ROW_W:0]       box_max_row;
        logic [COL_W:0]       box_max_col;
    } res_t;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LATCH,
        S_SCAN,
        S_WRITE
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic latch;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic need_scan;
        logic scan_last;
        logic res_free;
    } ctrl_sts_t;

    // row offset of neighbour k, two's complement
    function automatic logic [ROW_W:0] nb_drow(input logic [NB_IDX_W-1:0] k);
        logic [ROW_W:0] d;
        unique case (k)
            3'd0, 3'd1, 3'd2: d = '1;
            3'd3, 3'd4:       d = '0;
            default:          d = (ROW_W+1)'(1);
        endcase
        return d;
    endfunction

    // column offset of neighbour k, two's complement
    function automatic logic [COL_W:0] nb_dcol(input logic [NB_IDX_W-1:0] k);
        logic [COL_W:0] d;
        unique case (k)
            3'd0, 3'd3, 3'd5: d = '1;
            3'd1, 3'd6:       d = '0;
            default:          d = (COL_W+1)'(1);
        endcase
        return d;
    endfunction

    // linear cell address, row major
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(32'(r) * GRID_COLS + 32'(c));
    endfunction

endpackage

FILE: rtl/ocsu_ram.sv
// generic single-port ram with registered read
module ocsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ocsu_ctrl.sv
// controller state machine sequencing clear, read, neighbour scan and write back
module ocsu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ocsu_pkg::ctrl_sts_t  sts,
    output ocsu_pkg::ctrl_cmd_t  cmd
);

    ocsu_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ocsu_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ocsu_pkg::S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ocsu_pkg::S_IDLE;
                end
            end
            ocsu_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ocsu_pkg::S_READ;
                end
            end
            ocsu_pkg::S_READ:
            begin
                state_next = ocsu_pkg::S_LATCH;
            end
            ocsu_pkg::S_LATCH:
            begin
                state_next = sts.need_scan ? ocsu_pkg::S_SCAN : ocsu_pkg::S_WRITE;
            end
            ocsu_pkg::S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ocsu_pkg::S_WRITE;
                end
            end
            ocsu_pkg::S_WRITE:
            begin
                if (sts.res_free)
                begin
                    state_next = ocsu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ocsu_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ocsu_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ocsu_pkg::S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ocsu_pkg::S_READ:
            begin
            end
            ocsu_pkg::S_LATCH:
            begin
                cmd.latch = 1'b1;
            end
            ocsu_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ocsu_pkg::S_WRITE:
            begin
                cmd.commit = sts.res_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/ocsu_dp.sv
// datapath: cell stores, neighbour scan, state rules, counters and result register
module ocsu_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ocsu_pkg::req_t       req_data,
    input  ocsu_pkg::ctrl_cmd_t  cmd,
    output ocsu_pkg::ctrl_sts_t  sts,
    output logic                 res_valid,
    input  logic                 res_stall,
    output ocsu_pkg::res_t       res_data
);

    // request and per-item working registers
    ocsu_pkg::req_t                           req_reg, req_next;
    logic [ocsu_pkg::STATE_W-1:0]             prior_reg, prior_next;
    logic [ocsu_pkg::VIEW_BITS-1:0]           views_reg, views_next;
    logic [ocsu_pkg::NB_CNT_W-1:0]            nb_cnt_reg, nb_cnt_next;
    logic                                     nb_vld_reg, nb_vld_next;
    logic                                     free_found_reg, free_found_next;

    // architectural state
    logic [ocsu_pkg::FRONT_W-1:0]             frontier_reg, frontier_next;
    logic [ocsu_pkg::ROW_W-1:0]               min_row_reg, min_row_next;
    logic [ocsu_pkg::COL_W-1:0]               min_col_reg, min_col_next;
    logic [ocsu_pkg::ROW_W:0]                 max_row_reg, max_row_next;
    logic [ocsu_pkg::COL_W:0]                 max_col_reg, max_col_next;
    logic [ocsu_pkg::ADDR_W-1:0]              clear_addr_reg, clear_addr_next;

    // result register
    ocsu_pkg::res_t                           res_reg, res_next;
    logic                                     res_valid_reg, res_valid_next;

    // memory ports
    logic                                     state_we, views_we;
    logic [ocsu_pkg::ADDR_W-1:0]              state_addr, views_addr;
    logic [ocsu_pkg::STATE_W-1:0]             state_wdata, state_rdata;
    logic [ocsu_pkg::VIEW_BITS-1:0]           views_wdata, views_rdata;

    // decode
    logic                                     on_grid, want_ok;
    logic [ocsu_pkg::ADDR_W-1:0]              cell_a, nb_a;
    logic [ocsu_pkg::ROW_W:0]                 nb_r;
    logic [ocsu_pkg::COL_W:0]                 nb_c;
    logic                                     nb_in;
    logic                                     accept, apply;
    logic [ocsu_pkg::VIEW_BITS-1:0]           views_new;
    logic [ocsu_pkg::STATE_W-1:0]             want;

    ocsu_ram #(
        .WIDTH (ocsu_pkg::STATE_W),
        .DEPTH (ocsu_pkg::CELLS)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .addr  (state_addr),
        .wdata (state_wdata),
        .rdata (state_rdata)
    );

    ocsu_ram #(
        .WIDTH (ocsu_pkg::VIEW_BITS),
        .DEPTH (ocsu_pkg::CELLS)
    ) u_views_ram (
        .clk   (clk),
        .we    (views_we),
        .addr  (views_addr),
        .wdata (views_wdata),
        .rdata (views_rdata)
    );

    // request decode and neighbour address
    always_comb
    begin
        want    = req_reg.wanted_state;
        on_grid = (32'(req_reg.cell_row) < ocsu_pkg::GRID_ROWS) &&
                  (32'(req_reg.cell_col) < ocsu_pkg::GRID_COLS);
        want_ok = (want <= ocsu_pkg::ST_FRONTIER);
        cell_a  = ocsu_pkg::cell_addr(req_reg.cell_row, req_reg.cell_col);
        nb_r    = {1'b0, req_reg.cell_row} +
                  ocsu_pkg::nb_drow(nb_cnt_reg[ocsu_pkg::NB_IDX_W-1:0]);
        nb_c    = {1'b0, req_reg.cell_col} +
                  ocsu_pkg::nb_dcol(nb_cnt_reg[ocsu_pkg::NB_IDX_W-1:0]);
        // a wrap below zero or a step past the last index sets the top bit
        nb_in   = !nb_r[ocsu_pkg::ROW_W] && !nb_c[ocsu_pkg::COL_W] &&
                  (32'(nb_r[ocsu_pkg::ROW_W-1:0]) < ocsu_pkg::GRID_ROWS) &&
                  (32'(nb_c[ocsu_pkg::COL_W-1:0]) < ocsu_pkg::GRID_COLS);
        nb_a    = ocsu_pkg::cell_addr(nb_r[ocsu_pkg::ROW_W-1:0], nb_c[ocsu_pkg::COL_W-1:0]);
    end

    // state rules on the latched cell
    always_comb
    begin
        accept = on_grid && want_ok && (prior_reg != ocsu_pkg::ST_OCCUPIED) &&
                 !((want == ocsu_pkg::ST_OCCUPIED) && !free_found_reg);
        apply  = accept &&
                 !((prior_reg == ocsu_pkg::ST_VISITED) && (want != ocsu_pkg::ST_OCCUPIED)) &&
                 !((prior_reg == ocsu_pkg::ST_FREE) && (want == ocsu_pkg::ST_FRONTIER) &&
                   !req_reg.force_req);
        views_new = (accept && (views_reg != ocsu_pkg::VIEW_MAX)) ?
                    views_reg + ocsu_pkg::VIEW_BITS'(1) : views_reg;
    end

    // memory port control
    always_comb
    begin
        state_we    = cmd.clear_wr || (cmd.commit && apply);
        views_we    = cmd.clear_wr || (cmd.commit && accept);
        state_wdata = cmd.clear_wr ? ocsu_pkg::ST_UNKNOWN : want;
        views_wdata = cmd.clear_wr ? '0 : views_new;
        if (cmd.clear_wr)
        begin
            state_addr = clear_addr_reg;
        end
        else if (cmd.scan)
        begin
            state_addr = nb_a;
        end
        else
        begin
            state_addr = cell_a;
        end
        views_addr = cmd.clear_wr ? clear_addr_reg : cell_a;
    end

    // next values of working and architectural registers
    always_comb
    begin
        req_next        = cmd.capture ? req_data : req_reg;
        prior_next      = prior_reg;
        views_next      = views_reg;
        nb_cnt_next     = nb_cnt_reg;
        nb_vld_next     = 1'b0;
        free_found_next = free_found_reg;
        frontier_next   = frontier_reg;
        min_row_next    = min_row_reg;
        min_col_next    = min_col_reg;
        max_row_next    = max_row_reg;
        max_col_next    = max_col_reg;
        clear_addr_next = clear_addr_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && res_stall;

        // clearing sweep
        if (cmd.clear_wr)
        begin
            clear_addr_next = clear_addr_reg + ocsu_pkg::ADDR_W'(1);
        end

        // new item
        if (cmd.capture)
        begin
            nb_cnt_next     = '0;
            free_found_next = 1'b0;
        end

        // cell read data arrives, bounding box follows the request
        if (cmd.latch)
        begin
            prior_next = state_rdata;
            views_next = views_rdata;
            if (on_grid && want_ok)
            begin
                if (req_reg.cell_row < min_row_reg)
                begin
                    min_row_next = req_reg.cell_row;
                end
                if ({1'b0, req_reg.cell_row} > max_row_reg)
                begin
                    max_row_next = {1'b0, req_reg.cell_row} + (ocsu_pkg::ROW_W+1)'(1);
                end
                if (req_reg.cell_col < min_col_reg)
                begin
                    min_col_next = req_reg.cell_col;
                end
                if ({1'b0, req_reg.cell_col} > max_col_reg)
                begin
                    max_col_next = {1'b0, req_reg.cell_col} + (ocsu_pkg::COL_W+1)'(1);
                end
            end
        end

        // neighbour scan: issue one read, check the previous one
        if (cmd.scan)
        begin
            nb_cnt_next = nb_cnt_reg + ocsu_pkg::NB_CNT_W'(1);
            nb_vld_next = !sts.scan_last && nb_in;
            if (nb_vld_reg && (state_rdata == ocsu_pkg::ST_FREE))
            begin
                free_found_next = 1'b1;
            end
        end

        // write back and result
        if (cmd.commit)
        begin
            if (apply)
            begin
                if ((prior_reg != ocsu_pkg::ST_FRONTIER) && (want == ocsu_pkg::ST_FRONTIER))
                begin
                    frontier_next = frontier_reg + ocsu_pkg::FRONT_W'(1);
                end
                else if ((prior_reg == ocsu_pkg::ST_FRONTIER) &&
                         (want != ocsu_pkg::ST_FRONTIER) && (frontier_reg != '0))
                begin
                    frontier_next = frontier_reg - ocsu_pkg::FRONT_W'(1);
                end
            end
            res_next.applied        = apply;
            res_next.prior_state    = on_grid ? prior_reg : ocsu_pkg::ST_UNKNOWN;
            res_next.stored_state   = !on_grid ? ocsu_pkg::ST_UNKNOWN :
                                      (apply ? want : prior_reg);
            res_next.view_count     = on_grid ? 16'(views_new) : '0;
            res_next.frontier_total = frontier_next;
            res_next.box_min_row    = min_row_reg;
            res_next.box_min_col    = min_col_reg;
            res_next.box_max_row    = max_row_reg;
            res_next.box_max_col    = max_col_reg;
            res_valid_next          = 1'b1;
        end
    end

    // status to controller
    always_comb
    begin
        sts.clear_last = (clear_addr_reg == ocsu_pkg::ADDR_W'(ocsu_pkg::CELLS - 1));
        sts.need_scan  = on_grid && want_ok && (want == ocsu_pkg::ST_OCCUPIED) &&
                         (state_rdata != ocsu_pkg::ST_OCCUPIED);
        sts.scan_last  = (nb_cnt_reg == ocsu_pkg::NB_CNT_W'(ocsu_pkg::NB_COUNT));
        sts.res_free   = !res_valid_reg || !res_stall;
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_cnt_reg     <= '0;
            nb_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            frontier_reg   <= '0;
            min_row_reg    <= ocsu_pkg::ROW_W'(127);
            min_col_reg    <= ocsu_pkg::COL_W'(127);
            max_row_reg    <= '0;
            max_col_reg    <= '0;
            clear_addr_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            nb_cnt_reg     <= nb_cnt_next;
            nb_vld_reg     <= nb_vld_next;
            free_found_reg <= free_found_next;
            frontier_reg   <= frontier_next;
            min_row_reg    <= min_row_next;
            min_col_reg    <= min_col_next;
            max_row_reg    <= max_row_next;
            max_col_reg    <= max_col_next;
            clear_addr_reg <= clear_addr_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        prior_reg <= prior_next;
        views_reg <= views_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

FILE: rtl/occupancy_cell_state_update.sv
// top level: occupancy grid cell state update with single-port cell stores
// sequence: an accepted request passes through the read, latch and write states, and the result is
//   registered on write; an occupied request first scans its eight neighbours, one state-memory
//   read per neighbour; write back waits while a stalled result is held, and no new request is
//   taken until it is done; at reset a clearing pass writes all 16384 cells to unknown with zero views,
//   during which no item is accepted; counters and bounding box reset at once
module occupancy_cell_state_update (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ocsu_pkg::req_t  req_data,
    output logic            res_valid,
    input  logic            res_stall,
    output ocsu_pkg::res_t  res_data
);

    ocsu_pkg::ctrl_cmd_t cmd;
    ocsu_pkg::ctrl_sts_t sts;

    // sequencer
    ocsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores and update logic
    ocsu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

FILE: tb/sv/tb_occupancy_cell_state_update.sv
// testbench for the occupancy cell state update block: table and random phases
`timescale 1ns / 100ps

module tb_occupancy_cell_state_update;

    import ocsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 80000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int MAX_WAIT       = 12;
    localparam int RANDOM_BLOCKS  = 8;
    localparam int BLOCK_ITEMS    = 50;
    localparam int WINDOW         = 6;

    // state codes outside the legal range
    localparam logic [STATE_W-1:0] CODE_BAD_LOW  = 3'd5;
    localparam logic [STATE_W-1:0] CODE_BAD_MID  = 3'd6;
    localparam logic [STATE_W-1:0] CODE_BAD_HIGH = 3'd7;

    // results that follow straight from the reset state
    localparam res_t RES_UNTOUCHED = '{1'b0, ST_UNKNOWN, ST_UNKNOWN, 16'd0, 15'd0,
                                       7'd127, 7'd127, 8'd0, 8'd0};
    localparam res_t RES_CORNER_REJECT = '{1'b0, ST_UNKNOWN, ST_UNKNOWN, 16'd0, 15'd0,
                                           7'd0, 7'd0, 8'd0, 8'd0};
    localparam res_t RES_FAR_CORNER_FREE = '{1'b1, ST_UNKNOWN, ST_FREE, 16'd1, 15'd0,
                                             7'd0, 7'd0, 8'd128, 8'd128};

    typedef struct {
        req_t req;
        bit   fixed;
        res_t result;
    } table_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    // shadow copy of the grid and the running totals
    logic [STATE_W-1:0]   grid_state [CELLS];
    logic [VIEW_BITS-1:0] grid_views [CELLS];
    int unsigned          frontier_cells;
    logic [ROW_W-1:0]     box_lo_row;
    logic [COL_W-1:0]     box_lo_col;
    logic [ROW_W:0]       box_hi_row;
    logic [COL_W:0]       box_hi_col;

    res_t       pending_results [$];
    table_row_t stim_table [$];
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         no_idle     = 1'b0;

    occupancy_cell_state_update i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    // wait length for one item on either side
    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // apply one request to the shadow grid and return the result it yields
    function automatic res_t update_cell(input req_t req);
        res_t         r;
        int           idx;
        int           dr;
        int           dc;
        int           nr;
        int           nc;
        logic         has_free;
        logic [2:0]   prior;
        logic [2:0]   want;
        r = '0;
        idx = int'(req.cell_row) * GRID_COLS + int'(req.cell_col);
        prior = grid_state[idx];
        want = req.wanted_state;
        r.prior_state = prior;
        r.stored_state = prior;
        if (want <= ST_FRONTIER)
        begin
            // box moves before any state rule, max keeps index plus one
            if (req.cell_row < box_lo_row)
                box_lo_row = req.cell_row;
            if ({1'b0, req.cell_row} > box_hi_row)
                box_hi_row = {1'b0, req.cell_row} + 8'd1;
            if (req.cell_col < box_lo_col)
                box_lo_col = req.cell_col;
            if ({1'b0, req.cell_col} > box_hi_col)
                box_hi_col = {1'b0, req.cell_col} + 8'd1;
            // off-grid neighbours never count as free
            has_free = 1'b0;
            for (dr = -1; dr <= 1; dr++)
            begin
                for (dc = -1; dc <= 1; dc++)
                begin
                    nr = int'(req.cell_row) + dr;
                    nc = int'(req.cell_col) + dc;
                    if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 &&
                        nr < GRID_ROWS && nc < GRID_COLS)
                    begin
                        if (grid_state[nr * GRID_COLS + nc] == ST_FREE)
                            has_free = 1'b1;
                    end
                end
            end
            if (prior != ST_OCCUPIED && !(want == ST_OCCUPIED && !has_free))
            begin
                if (grid_views[idx] != VIEW_MAX)
                    grid_views[idx] = grid_views[idx] + 1'b1;
                if (!(prior == ST_VISITED && want != ST_OCCUPIED) &&
                    !(prior == ST_FREE && want == ST_FRONTIER && !req.force_req))
                begin
                    if (prior != ST_FRONTIER && want == ST_FRONTIER)
                        frontier_cells++;
                    else if (prior == ST_FRONTIER && want != ST_FRONTIER &&
                             frontier_cells > 0)
                        frontier_cells--;
                    grid_state[idx] = want;
                    r.stored_state = want;
                    r.applied = 1'b1;
                end
            end
        end
        r.view_count = grid_views[idx];
        r.frontier_total = FRONT_W'(frontier_cells);
        r.box_min_row = box_lo_row;
        r.box_min_col = box_lo_col;
        r.box_max_row = box_hi_row;
        r.box_max_col = box_hi_col;
        return r;
    endfunction

    task automatic add_row(input int row, input int col, input logic [2:0] want,
                           input bit frc, input bit fixed, input res_t result);
        table_row_t t;
        t.req.cell_row = ROW_W'(row);
        t.req.cell_col = COL_W'(col);
        t.req.wanted_state = want;
        t.req.force_req = frc;
        t.fixed = fixed;
        t.result = result;
        stim_table.insert(stim_table.size(), t);
    endtask

    // append one prediction behind the ones still outstanding
    task automatic queue_result(input res_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // present one item after a gap and return at the edge that takes it
    task automatic send_request(input req_t item);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // result side: compare each taken item with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %h", $time, res_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("applied", want.applied, res_data.applied);
                check_field("prior_state", want.prior_state, res_data.prior_state);
                check_field("stored_state", want.stored_state, res_data.stored_state);
                check_field("view_count", want.view_count, res_data.view_count);
                check_field("frontier_total", want.frontier_total, res_data.frontier_total);
                check_field("box_min_row", want.box_min_row, res_data.box_min_row);
                check_field("box_min_col", want.box_min_col, res_data.box_min_col);
                check_field("box_max_row", want.box_max_row, res_data.box_max_row);
                check_field("box_max_col", want.box_max_col, res_data.box_max_col);
            end
        end
    end

    // cycles with no item taken on either side
    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (res_valid === 1'b1 && res_stall == 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // receiver stall per item
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(res_valid === 1'b1 && res_stall == 1'b0));
        end
    end

    // stimulus
    initial
    begin
        req_t item;
        res_t predicted;
        int   base_row;
        int   base_col;

        for (int i = 0; i < CELLS; i++)
        begin
            grid_state[i] = ST_UNKNOWN;
            grid_views[i] = '0;
        end
        frontier_cells = 0;
        box_lo_row = 7'd127;
        box_lo_col = 7'd127;
        box_hi_row = '0;
        box_hi_col = '0;

        // bad codes and corner requests on the fresh grid
        add_row(0, 0, CODE_BAD_LOW, 1'b0, 1'b1, RES_UNTOUCHED);
        add_row(127, 127, CODE_BAD_HIGH, 1'b1, 1'b1, RES_UNTOUCHED);
        add_row(0, 0, ST_OCCUPIED, 1'b0, 1'b1, RES_CORNER_REJECT);
        add_row(127, 127, ST_FREE, 1'b0, 1'b1, RES_FAR_CORNER_FREE);
        // occupied next to a free cell, then held
        add_row(126, 126, ST_OCCUPIED, 1'b1, 1'b0, '0);
        add_row(126, 126, ST_FREE, 1'b0, 1'b0, '0);
        add_row(127, 127, ST_UNKNOWN, 1'b0, 1'b0, '0);
        add_row(0, 1, ST_FREE, 1'b1, 1'b0, '0);
        add_row(0, 0, ST_OCCUPIED, 1'b0, 1'b0, '0);
        // free to frontier with and without force
        add_row(5, 5, ST_FREE, 1'b0, 1'b0, '0);
        add_row(5, 5, ST_FRONTIER, 1'b0, 1'b0, '0);
        add_row(5, 5, ST_FRONTIER, 1'b1, 1'b0, '0);
        add_row(5, 5, ST_FRONTIER, 1'b1, 1'b0, '0);
        add_row(5, 7, ST_FRONTIER, 1'b0, 1'b0, '0);
        // visited holds against all but occupied
        add_row(5, 6, ST_VISITED, 1'b1, 1'b0, '0);
        add_row(5, 6, ST_FREE, 1'b0, 1'b0, '0);
        add_row(4, 7, ST_FREE, 1'b0, 1'b0, '0);
        add_row(5, 6, ST_OCCUPIED, 1'b0, 1'b0, '0);
        add_row(5, 7, ST_OCCUPIED, 1'b0, 1'b0, '0);
        add_row(5, 5, ST_UNKNOWN, 1'b0, 1'b0, '0);
        // edge cells whose neighbours fall off the grid
        add_row(0, 127, ST_OCCUPIED, 1'b0, 1'b0, '0);
        add_row(127, 0, ST_OCCUPIED, 1'b1, 1'b0, '0);
        // bad codes report the current cell
        add_row(64, 64, CODE_BAD_MID, 1'b1, 1'b0, '0);
        add_row(0, 1, CODE_BAD_LOW, 1'b0, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (stim_table[i])
        begin
            send_request(stim_table[i].req);
            predicted = update_cell(stim_table[i].req);
            queue_result(stim_table[i].fixed ? stim_table[i].result : predicted);
        end
        pause_until_drained();

        // random blocks, mostly inside a small window so neighbours interact
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            no_idle = (blk % 4 == 3);
            case ($urandom_range(0, 3))
                0:       base_row = 0;
                1:       base_row = GRID_ROWS - WINDOW;
                default: base_row = $urandom_range(0, GRID_ROWS - WINDOW);
            endcase
            case ($urandom_range(0, 3))
                0:       base_col = 0;
                1:       base_col = GRID_COLS - WINDOW;
                default: base_col = $urandom_range(0, GRID_COLS - WINDOW);
            endcase
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    item.cell_row = ROW_W'(base_row + $urandom_range(0, WINDOW - 1));
                    item.cell_col = COL_W'(base_col + $urandom_range(0, WINDOW - 1));
                end
                else
                begin
                    item.cell_row = ROW_W'($urandom_range(0, GRID_ROWS - 1));
                    item.cell_col = COL_W'($urandom_range(0, GRID_COLS - 1));
                end
                if ($urandom_range(0, 99) < 90)
                    item.wanted_state = STATE_W'($urandom_range(ST_UNKNOWN, ST_FRONTIER));
                else
                    item.wanted_state = STATE_W'($urandom_range(CODE_BAD_LOW, CODE_BAD_HIGH));
                item.force_req = 1'($urandom_range(0, 1));
                send_request(item);
                queue_result(update_cell(item));
            end
            // hold off until every result is back
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
